@@ rtl/tps_pkg.sv @@
// Shared constants and helpers for the triangle pair separating axis test.
// No dependencies.
`default_nettype none

package tps_pkg;

  localparam int FIELD_WIDTH = 48;   // packed vertex field
  localparam int THR_WIDTH   = 40;   // squared length threshold
  localparam int SEL_WIDTH   = 4;    // axis index
  localparam int NUM_AXES    = 11;
  localparam int NUM_VTX     = 6;    // A0..A2, B0..B2
  localparam int BIG_BITS    = 20;   // |component| >= 2^20 always beats the threshold

  localparam logic [SEL_WIDTH-1:0] AXIS_NONE = 4'd11;

  // Edge feeding the left operand of axis n (edges 0..2 of A, 3..5 of B).
  function automatic int axis_left(input int n);
    int r;
    case (n)
      1:         r = 3;
      5, 6, 7:   r = 1;
      8, 9, 10:  r = 2;
      default:   r = 0;
    endcase
    return r;
  endfunction

  // Edge feeding the right operand of axis n.
  function automatic int axis_right(input int n);
    int r;
    case (n)
      0:         r = 1;
      1:         r = 4;
      2, 5, 8:   r = 3;
      3, 6, 9:   r = 4;
      default:   r = 5;
    endcase
    return r;
  endfunction

  // Next component index, wrapping z back to x.
  function automatic int next_comp(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tps_ifs.sv @@
// Channel interfaces of the triangle pair overlap block: input pair,
// result and threshold write. Depends on tps_pkg.
`default_nettype none

interface tps_in_if import tps_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] tri_a_v0;
  logic [FIELD_WIDTH-1:0] tri_a_v1;
  logic [FIELD_WIDTH-1:0] tri_a_v2;
  logic [FIELD_WIDTH-1:0] tri_b_v0;
  logic [FIELD_WIDTH-1:0] tri_b_v1;
  logic [FIELD_WIDTH-1:0] tri_b_v2;

  modport source (output valid, tri_a_v0, tri_a_v1, tri_a_v2,
                  tri_b_v0, tri_b_v1, tri_b_v2, input ready);
  modport sink   (input valid, tri_a_v0, tri_a_v1, tri_a_v2,
                  tri_b_v0, tri_b_v1, tri_b_v2, output ready);
endinterface

interface tps_out_if import tps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 overlaps;
  logic [SEL_WIDTH-1:0] separating_axis;

  modport source (output valid, overlaps, separating_axis, input ready);
  modport sink   (input valid, overlaps, separating_axis, output ready);
endinterface

interface tps_cfg_if import tps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [THR_WIDTH-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/triangle_pair_sat_overlap.sv @@
// Triangle pair overlap test by separating axes, fully pipelined.
// Depends on tps_pkg and the interfaces in tps_ifs.sv.
//
// Usage:
//   tri_pair : one transfer carries two triangles (six packed vertices,
//              x,y,z signed fixed point of COORD_WIDTH bits each).
//   result   : one transfer per pair: overlaps, and the index of the first
//              separating axis (0,1 face normals, 2..10 edge crosses,
//              11 when the triangles overlap).
//   cfg      : write of min_axis_len_sq; an axis whose squared length is
//              not above it is skipped. Write only while the pipe is empty.
// Throughput: one pair per cycle unless result is held off; eight
//   register stages (unpack, edges, cross partial products, axes,
//   dot/square products, sums, interval bounds, verdict) each hold
//   one pair.
// Stall: when result is held off, the whole pipe freezes and tri_pair
//   ready drops; nothing is lost or repeated. Empty slots inside the pipe
//   stay in place while it is frozen.
// Reset: clears all stage valid bits and sets the threshold to 0.
`default_nettype none

module triangle_pair_sat_overlap import tps_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tps_in_if.sink    tri_pair,
  tps_cfg_if.sink   cfg,
  tps_out_if.source result
);

  localparam int W   = COORD_WIDTH;
  localparam int EW  = W + 1;        // edge component
  localparam int PW  = 2 * EW;       // cross partial product
  localparam int AW  = PW + 1;       // axis component
  localparam int DW  = AW + W;       // axis * coordinate
  localparam int SW  = DW + 2;       // projection (sum of three)
  localparam int SQW = 2 * BIG_BITS; // square of a small component
  localparam int LW  = SQW + 2;      // squared length

  // Whole pipe advances together; a free output slot or a taker drains it.
  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, vo;

  assign en             = !vo || result.ready;
  assign tri_pair.ready = en && !rst;
  assign cfg.ready      = !rst;

  // Threshold register.
  logic [THR_WIDTH-1:0] thr;
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg.valid && cfg.ready) begin
      thr <= cfg.data;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, vo} <= '0;
    end else if (en) begin
      v1 <= tri_pair.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      vo <= v7;
    end
  end

  // Stage 1: unpack vertices. Missing high bits read as zero.
  logic [FIELD_WIDTH-1:0] fields [NUM_VTX];
  logic [3*W-1:0]         packed3 [NUM_VTX];
  logic signed [W-1:0]    vtx1 [NUM_VTX][3];

  assign fields[0] = tri_pair.tri_a_v0;
  assign fields[1] = tri_pair.tri_a_v1;
  assign fields[2] = tri_pair.tri_a_v2;
  assign fields[3] = tri_pair.tri_b_v0;
  assign fields[4] = tri_pair.tri_b_v1;
  assign fields[5] = tri_pair.tri_b_v2;

  always_comb begin
    for (int m = 0; m < NUM_VTX; m++) begin
      packed3[m] = (3*W)'(fields[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < NUM_VTX; m++) begin
        vtx1[m][0] <= packed3[m][3*W-1:2*W];
        vtx1[m][1] <= packed3[m][2*W-1:W];
        vtx1[m][2] <= packed3[m][W-1:0];
      end
    end
  end

  // Stage 2: edges v1-v0, v2-v1, v0-v2 of each triangle.
  logic signed [W-1:0]  vtx2 [NUM_VTX][3];
  logic signed [EW-1:0] edge2 [NUM_VTX][3];

  always_ff @(posedge clk) begin
    if (en) begin
      vtx2 <= vtx1;
      for (int t = 0; t < 2; t++) begin
        for (int e = 0; e < 3; e++) begin
          for (int k = 0; k < 3; k++) begin
            edge2[3*t+e][k] <= EW'(vtx1[3*t+next_comp(e)][k]) - EW'(vtx1[3*t+e][k]);
          end
        end
      end
    end
  end

  // Stage 3: the two partial products of each cross product component.
  logic signed [W-1:0]  vtx3 [NUM_VTX][3];
  logic signed [PW-1:0] xp3 [NUM_AXES][3][2];

  always_ff @(posedge clk) begin
    if (en) begin
      vtx3 <= vtx2;
      for (int n = 0; n < NUM_AXES; n++) begin
        for (int k = 0; k < 3; k++) begin
          xp3[n][k][0] <= edge2[axis_left(n)][next_comp(k)]
                        * edge2[axis_right(n)][next_comp(next_comp(k))];
          xp3[n][k][1] <= edge2[axis_left(n)][next_comp(next_comp(k))]
                        * edge2[axis_right(n)][next_comp(k)];
        end
      end
    end
  end

  // Stage 4: axis components.
  logic signed [W-1:0]  vtx4 [NUM_VTX][3];
  logic signed [AW-1:0] axis4 [NUM_AXES][3];

  always_ff @(posedge clk) begin
    if (en) begin
      vtx4 <= vtx3;
      for (int n = 0; n < NUM_AXES; n++) begin
        for (int k = 0; k < 3; k++) begin
          axis4[n][k] <= AW'(xp3[n][k][0]) - AW'(xp3[n][k][1]);
        end
      end
    end
  end

  // Stage 5: projection products, component squares and the large flag.
  logic [AW-1:0]        mag [NUM_AXES][3];
  logic [BIG_BITS-1:0]  mag_lo [NUM_AXES][3];
  logic signed [DW-1:0] dp5 [NUM_AXES][NUM_VTX][3];
  logic [SQW-1:0]       sq5 [NUM_AXES][3];
  logic                 big5 [NUM_AXES];

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int k = 0; k < 3; k++) begin
        mag[n][k]    = axis4[n][k][AW-1] ? AW'(-axis4[n][k]) : AW'(axis4[n][k]);
        mag_lo[n][k] = BIG_BITS'(mag[n][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_AXES; n++) begin
        big5[n] <= ((mag[n][0] >> BIG_BITS) != '0) || ((mag[n][1] >> BIG_BITS) != '0)
                || ((mag[n][2] >> BIG_BITS) != '0);
        for (int k = 0; k < 3; k++) begin
          sq5[n][k] <= SQW'(mag_lo[n][k]) * SQW'(mag_lo[n][k]);
          for (int m = 0; m < NUM_VTX; m++) begin
            dp5[n][m][k] <= axis4[n][k] * vtx4[m][k];
          end
        end
      end
    end
  end

  // Stage 6: projections and axis usable flag.
  logic signed [SW-1:0] proj6 [NUM_AXES][NUM_VTX];
  logic                 used6 [NUM_AXES];
  logic [LW-1:0]        len_sq [NUM_AXES];

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      len_sq[n] = LW'(sq5[n][0]) + LW'(sq5[n][1]) + LW'(sq5[n][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NUM_AXES; n++) begin
        used6[n] <= big5[n] || (len_sq[n] > LW'(thr));
        for (int m = 0; m < NUM_VTX; m++) begin
          proj6[n][m] <= SW'(dp5[n][m][0]) + SW'(dp5[n][m][1]) + SW'(dp5[n][m][2]);
        end
      end
    end
  end

  // Stage 7: interval bounds of each triangle on each axis.
  logic signed [SW-1:0] lo7 [NUM_AXES][2];
  logic signed [SW-1:0] hi7 [NUM_AXES][2];
  logic signed [SW-1:0] mn [NUM_AXES][2];
  logic signed [SW-1:0] mx [NUM_AXES][2];
  logic                 used7 [NUM_AXES];

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int t = 0; t < 2; t++) begin
        mn[n][t] = proj6[n][3*t];
        mx[n][t] = proj6[n][3*t];
        for (int m = 1; m < 3; m++) begin
          if (proj6[n][3*t+m] < mn[n][t]) begin
            mn[n][t] = proj6[n][3*t+m];
          end
          if (proj6[n][3*t+m] > mx[n][t]) begin
            mx[n][t] = proj6[n][3*t+m];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo7   <= mn;
      hi7   <= mx;
      used7 <= used6;
    end
  end

  // Stage 8: disjoint test (touching is overlap), lowest axis wins.
  logic [NUM_AXES-1:0]  sep;
  logic [SEL_WIDTH-1:0] first_sep;

  always_comb begin
    first_sep = AXIS_NONE;
    for (int n = 0; n < NUM_AXES; n++) begin
      sep[n] = used7[n] && ((hi7[n][0] < lo7[n][1]) || (hi7[n][1] < lo7[n][0]));
    end
    for (int n = NUM_AXES - 1; n >= 0; n--) begin
      if (sep[n]) begin
        first_sep = SEL_WIDTH'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.overlaps        <= (sep == '0);
      result.separating_axis <= first_sep;
    end
  end

  assign result.valid = vo;

  // Checks.
  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    vo |-> (result.overlaps == (result.separating_axis == AXIS_NONE)))
    else $error("overlaps disagrees with separating_axis");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    vo |-> (result.separating_axis <= AXIS_NONE))
    else $error("separating_axis out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (tri_pair.valid && tri_pair.ready) |=> v1)
    else $error("accepted pair did not enter the pipe");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vo && !result.ready) |=> (vo && $stable(result.separating_axis)))
    else $error("result dropped during stall");

endmodule

`default_nettype wire

@@ sim/triangle_pair_sat_overlap_test.sv @@
// Self-checking bench for triangle_pair_sat_overlap: queued triangle pairs,
// with an in-bench separating axis predictor checking every verdict.
// Depends on tps_pkg, tps_ifs.sv and the block's RTL.
`default_nettype none

module triangle_pair_sat_overlap_test import tps_pkg::*; ();

  localparam int W        = 16;
  localparam int DOG_MAX  = 20000;   // idle cycles before giving up
  localparam int HOLD_LEN = 300;     // long result hold-off

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] a0, a1, a2, b0, b1, b2;
  } pair_t;

  typedef struct packed {
    logic                 overlaps;
    logic [SEL_WIDTH-1:0] axis;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tps_in_if  in_ch ();
  tps_cfg_if cfg_ch ();
  tps_out_if res_ch ();

  triangle_pair_sat_overlap #(.COORD_WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .tri_pair (in_ch),
    .cfg      (cfg_ch),
    .result   (res_ch)
  );

  always #10 clk = ~clk;

  pair_t    pending_pairs[$];
  verdict_t verdicts_due[$];
  logic [THR_WIDTH-1:0] model_thr = '0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  send_pause    = 1'b0;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;
  bit  in_fired      = 1'b0;
  int  errors        = 0;
  int  dog           = 0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // Exact integer separating axis test; axes left unnormalized.
  function automatic verdict_t sat_verdict(input pair_t p, input logic [THR_WIDTH-1:0] thr);
    logic [FIELD_WIDTH-1:0] f[6];
    longint v[6][3];
    longint e[6][3];
    longint ax[3];
    longint lo[2], hi[2], d, m;
    longint unsigned sq;
    int l, r, t, k, n;
    bit used;
    verdict_t res;
    f = '{p.a0, p.a1, p.a2, p.b0, p.b1, p.b2};
    for (t = 0; t < 6; t++) begin
      v[t][0] = longint'($signed(f[t][3*W-1:2*W]));
      v[t][1] = longint'($signed(f[t][2*W-1:W]));
      v[t][2] = longint'($signed(f[t][W-1:0]));
    end
    // edges 0..2 of A, 3..5 of B: v1-v0, v2-v1, v0-v2
    for (t = 0; t < 2; t++)
      for (k = 0; k < 3; k++) begin
        e[3*t][k]   = v[3*t+1][k] - v[3*t][k];
        e[3*t+1][k] = v[3*t+2][k] - v[3*t+1][k];
        e[3*t+2][k] = v[3*t][k]   - v[3*t+2][k];
      end
    res.overlaps = 1'b1;
    res.axis     = AXIS_NONE;
    for (n = 0; n < NUM_AXES; n++) begin
      if (n == 0) begin l = 0; r = 1; end
      else if (n == 1) begin l = 3; r = 4; end
      else begin l = (n - 2) / 3; r = 3 + (n - 2) % 3; end
      ax[0] = e[l][1] * e[r][2] - e[l][2] * e[r][1];
      ax[1] = e[l][2] * e[r][0] - e[l][0] * e[r][2];
      ax[2] = e[l][0] * e[r][1] - e[l][1] * e[r][0];
      used = 1'b0;
      sq = 0;
      for (k = 0; k < 3; k++) begin
        m = (ax[k] < 0) ? -ax[k] : ax[k];
        if (m >= (longint'(1) << BIG_BITS)) used = 1'b1;
        else sq += longint'(m * m);
      end
      if (!used && sq > longint'(thr)) used = 1'b1;
      if (!used) continue;
      for (t = 0; t < 2; t++) begin
        for (k = 0; k < 3; k++) begin
          d = ax[0] * v[3*t+k][0] + ax[1] * v[3*t+k][1] + ax[2] * v[3*t+k][2];
          if (k == 0 || d < lo[t]) lo[t] = d;
          if (k == 0 || d > hi[t]) hi[t] = d;
        end
      end
      if (hi[0] < lo[1] || hi[1] < lo[0]) begin
        res.overlaps = 1'b0;
        res.axis     = n[SEL_WIDTH-1:0];
        return res;
      end
    end
    return res;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] vtx(input int x, input int y, input int z);
    logic [W-1:0] cx, cy, cz;
    cx = x[W-1:0];
    cy = y[W-1:0];
    cz = z[W-1:0];
    return {cx, cy, cz};
  endfunction

  // Vertex near a base point; spread picks how tight the cluster is.
  function automatic logic [FIELD_WIDTH-1:0] near(input int bx, input int by, input int bz,
                                                  input int spread);
    return vtx(bx + $urandom_range(2 * spread) - spread, by + $urandom_range(2 * spread) - spread,
               bz + $urandom_range(2 * spread) - spread);
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int bx, by, bz, ox, oy, oz, sp, kind;
    kind = $urandom_range(9);
    if (kind < 2) begin
      // noise: every bit free
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    end else begin
      sp = (kind < 5) ? 64 : (kind < 8) ? 1024 : 12000;
      bx = $urandom_range(40000) - 20000;
      by = $urandom_range(40000) - 20000;
      bz = $urandom_range(40000) - 20000;
      ox = bx + $urandom_range(2 * sp) - sp;
      oy = by + $urandom_range(2 * sp) - sp;
      oz = bz + $urandom_range(2 * sp) - sp;
      p.a0 = near(bx, by, bz, sp);
      p.a1 = near(bx, by, bz, sp);
      p.a2 = (kind == 9) ? p.a1 : near(bx, by, bz, sp);   // sometimes degenerate
      p.b0 = near(ox, oy, oz, sp);
      p.b1 = near(ox, oy, oz, sp);
      p.b2 = near(ox, oy, oz, sp);
    end
    return p;
  endfunction

  // Append one pair to the tail of the pending list.
  task automatic queue_pair(input pair_t p);
    pending_pairs = {pending_pairs, p};
  endtask

  task automatic write_thr(input logic [THR_WIDTH-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    model_thr = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic add_directed();
    pair_t p;
    // all zero: nothing usable
    queue_pair('0);
    // coordinate extremes
    p = '{vtx(32767, 32767, 32767), vtx(-32768, -32768, -32768), vtx(32767, -32768, 0),
          vtx(-32768, 32767, 32767), vtx(0, 0, -32768), vtx(32767, 32767, -32768)};
    queue_pair(p);
    p = '{vtx(-32768, 0, 0), vtx(32767, 0, 0), vtx(0, 32767, 0),
          vtx(-32768, 0, 1), vtx(32767, 0, 1), vtx(0, -32768, 1)};
    queue_pair(p);
    // separated along z by face normal
    p = '{vtx(0, 0, 0), vtx(256, 0, 0), vtx(0, 256, 0),
          vtx(0, 0, 512), vtx(256, 0, 512), vtx(0, 256, 512)};
    queue_pair(p);
    // identical triangles
    p = '{vtx(10, 20, 30), vtx(300, 20, 30), vtx(10, 500, 90),
          vtx(10, 20, 30), vtx(300, 20, 30), vtx(10, 500, 90)};
    queue_pair(p);
    // touching at one shared vertex
    p = '{vtx(0, 0, 0), vtx(256, 0, 0), vtx(0, 256, 0),
          vtx(256, 0, 0), vtx(512, 0, 0), vtx(256, 0, 256)};
    queue_pair(p);
    // coplanar, side by side with a gap: no axis of the set separates them
    p = '{vtx(0, 0, 0), vtx(256, 0, 0), vtx(0, 256, 0),
          vtx(300, 300, 0), vtx(600, 300, 0), vtx(300, 600, 0)};
    queue_pair(p);
    // crossing triangles
    p = '{vtx(-256, 0, -256), vtx(256, 0, -256), vtx(0, 0, 256),
          vtx(0, -256, -128), vtx(0, 256, -128), vtx(0, 0, 300)};
    queue_pair(p);
    // degenerate point versus segment
    p = '{vtx(5, 5, 5), vtx(5, 5, 5), vtx(5, 5, 5),
          vtx(0, 0, 0), vtx(100, 100, 100), vtx(50, 50, 50)};
    queue_pair(p);
    // tiny triangles: axes at the threshold edge
    p = '{vtx(0, 0, 0), vtx(1, 0, 0), vtx(0, 1, 0),
          vtx(0, 0, 3), vtx(1, 0, 3), vtx(0, 1, 3)};
    queue_pair(p);
    // all ones in every field
    queue_pair('1);
  endtask

  task automatic add_random(input int count);
    repeat (count) queue_pair(random_pair());
  endtask

  // Input driver: hold a pending offer until it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_ch.valid && !in_fired) begin
        in_ch.valid <= 1'b1;
      end else if (pending_pairs.size() != 0 && !send_pause &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid    <= 1'b1;
        in_ch.tri_a_v0 <= pending_pairs[0].a0;
        in_ch.tri_a_v1 <= pending_pairs[0].a1;
        in_ch.tri_a_v2 <= pending_pairs[0].a2;
        in_ch.tri_b_v0 <= pending_pairs[0].b0;
        in_ch.tri_b_v1 <= pending_pairs[0].b1;
        in_ch.tri_b_v2 <= pending_pairs[0].b2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random ready, or a long counted hold-off on request.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Input transfer: predict and queue the verdict.
  always @(posedge clk) begin
    in_fired <= (!rst && in_ch.valid && in_ch.ready);
    if (!rst && in_ch.valid && in_ch.ready) begin
      verdicts_due = {verdicts_due, sat_verdict(pending_pairs[0], model_thr)};
      void'(pending_pairs.pop_front());
    end
  end

  // Result transfer: compare with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report("result with no pair outstanding");
      end else begin
        want = verdicts_due.pop_front();
        if (res_ch.overlaps !== want.overlaps)
          report($sformatf("overlaps got %b want %b", res_ch.overlaps, want.overlaps));
        if (res_ch.separating_axis !== want.axis)
          report($sformatf("separating_axis got %0d want %0d", res_ch.separating_axis,
                           want.axis));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      dog <= 0;
    end else if (dog >= DOG_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.tri_a_v0 = '0;
    in_ch.tri_a_v1 = '0;
    in_ch.tri_a_v2 = '0;
    in_ch.tri_b_v0 = '0;
    in_ch.tri_b_v1 = '0;
    in_ch.tri_b_v2 = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    res_ch.ready   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 1: reset threshold, sender idles more lightly
    send_idle_pct = 29;
    recv_idle_pct = 52;
    add_directed();
    add_random(500);
    drain();

    // phase 2: threshold of 1 then the top value, idling swapped
    write_thr(40'd1);
    add_directed();
    add_random(100);
    drain();
    write_thr({THR_WIDTH{1'b1}});
    send_idle_pct = 52;
    recv_idle_pct = 29;
    add_directed();
    add_random(500);
    drain();

    // phase 3: mid threshold, no idling; long hold-off, then a sender pause; then threshold 0
    write_thr(THR_WIDTH'({$urandom_range(255), $urandom}) >> $urandom_range(24));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(350);
    hold_req = 1'b1;
    while (pending_pairs.size() > 200) @(posedge clk);
    send_pause = 1'b1;
    while (verdicts_due.size() != 0) @(posedge clk);
    send_pause = 1'b0;
    drain();
    write_thr('0);
    add_random(300);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/tps_pkg.sv
rtl/tps_ifs.sv
rtl/triangle_pair_sat_overlap.sv
sim/triangle_pair_sat_overlap_test.sv
